>>> design/sit_pkg.sv
// Shared widths, constants and word types of the segment intersection test.
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

	// Coordinate and fixed-point format
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int PT_BITS    = 24;

	// Exact widths of the line equation and Cramer terms
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int CPROD_W = 2 * COORD_BITS + 1;
	localparam int DET_W   = 2 * DIFF_W + 1;
	localparam int NUM_W   = CPROD_W + DIFF_W + 1;
	localparam int BND_W   = COORD_BITS + DET_W;
	localparam int CMP_W   = ((BND_W > NUM_W) ? BND_W : NUM_W) + 1;

	// Divider: numerator magnitude scaled by the fraction bits, quotient digits
	localparam int MAG_W   = NUM_W + FRAC_BITS;
	localparam int QUO_W   = COORD_BITS + FRAC_BITS;
	localparam int SAT_W   = ((QUO_W + 1 > PT_BITS) ? QUO_W + 1 : PT_BITS) + 1;

	// Queue between classifier and divider
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Classified word handed from the front to the divider
	typedef struct packed {
		logic               hit;
		logic               coin;
		logic               proper;
		logic               neg_x;
		logic               neg_y;
		logic [NUM_W-1:0]   mag_x;
		logic [NUM_W-1:0]   mag_y;
		logic [DET_W-1:0]   den;
	} sit_job_t;

	// One stage of the two-lane restoring divider
	typedef struct packed {
		logic               hit;
		logic               coin;
		logic               proper;
		logic               neg_x;
		logic               neg_y;
		logic [DET_W-1:0]   den;
		logic [DET_W-1:0]   rem_x;
		logic [DET_W-1:0]   rem_y;
		logic [QUO_W-1:0]   low_x;
		logic [QUO_W-1:0]   low_y;
		logic [QUO_W-1:0]   q_x;
		logic [QUO_W-1:0]   q_y;
	} sit_div_t;

	// Result word
	typedef struct packed {
		logic                      hit;
		logic                      coin;
		logic signed [PT_BITS-1:0] px;
		logic signed [PT_BITS-1:0] py;
	} sit_res_t;

endpackage

`default_nettype wire

>>> design/sit_if.sv
// Valid/ready channel interfaces for segment pairs and intersection results.
`timescale 1ns / 1ps
`default_nettype none

interface sit_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [sit_pkg::COORD_BITS-1:0]   wall_ax;
	logic signed [sit_pkg::COORD_BITS-1:0]   wall_ay;
	logic signed [sit_pkg::COORD_BITS-1:0]   wall_bx;
	logic signed [sit_pkg::COORD_BITS-1:0]   wall_by;
	logic signed [sit_pkg::COORD_BITS-1:0]   shot_ax;
	logic signed [sit_pkg::COORD_BITS-1:0]   shot_ay;
	logic signed [sit_pkg::COORD_BITS-1:0]   shot_bx;
	logic signed [sit_pkg::COORD_BITS-1:0]   shot_by;

	modport source (
		output valid, wall_ax, wall_ay, wall_bx, wall_by,
		output shot_ax, shot_ay, shot_bx, shot_by,
		input  ready
	);
	modport sink (
		input  valid, wall_ax, wall_ay, wall_bx, wall_by,
		input  shot_ax, shot_ay, shot_bx, shot_by,
		output ready
	);
endinterface

interface sit_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 hit;
	logic                                 coincident;
	logic signed [sit_pkg::PT_BITS-1:0]   point_x;
	logic signed [sit_pkg::PT_BITS-1:0]   point_y;

	modport source (
		output valid, hit, coincident, point_x, point_y,
		input  ready
	);
	modport sink (
		input  valid, hit, coincident, point_x, point_y,
		output ready
	);
endinterface

`default_nettype wire

>>> design/sit_front.sv
// Front end: line equations, Cramer determinants, span products and hit classification.
`timescale 1ns / 1ps
`default_nettype none

module sit_front (
	input  logic              clk,
	input  logic              arst_n,
	sit_in_if.sink            in_ch,
	input  logic              full,
	output logic              push,
	output sit_pkg::sit_job_t job
);

	localparam int CW   = sit_pkg::COORD_BITS;
	localparam int DW   = sit_pkg::DIFF_W;
	localparam int CPW  = sit_pkg::CPROD_W;
	localparam int DETW = sit_pkg::DET_W;
	localparam int NW   = sit_pkg::NUM_W;
	localparam int BW   = sit_pkg::BND_W;
	localparam int CMPW = sit_pkg::CMP_W;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// Span selection of the incoming pair
	logic                 w_vert, s_horiz;
	logic signed [CW-1:0] w_p, w_r, s_p, s_r, wlo, whi, slo, shi;

	// Stage 1: differences and coordinate products
	logic signed [DW-1:0]   a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [2*CW-1:0] pw1_s1, pw2_s1, ps1_s1, ps2_s1;
	logic                   w_vert_s1, s_horiz_s1;
	logic signed [CW-1:0]   wlo_s1, whi_s1, slo_s1, shi_s1;

	// Stage 2: line constants and determinant products
	logic signed [DW-1:0]   a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CPW-1:0]  c1_s2, c2_s2;
	logic signed [2*DW-1:0] m1_s2, m2_s2;
	logic                   w_vert_s2, s_horiz_s2;
	logic signed [CW-1:0]   wlo_s2, whi_s2, slo_s2, shi_s2;

	// Stage 3: determinant and numerator products
	logic signed [DETW-1:0]   det_s3;
	logic signed [CPW+DW-1:0] pxa_s3, pxb_s3, pya_s3, pyb_s3;
	logic                     w_vert_s3, s_horiz_s3;
	logic signed [CW-1:0]     wlo_s3, whi_s3, slo_s3, shi_s3;

	// Stage 4: numerators and scaled span bounds
	logic signed [DETW-1:0] det_s4;
	logic signed [NW-1:0]   dx_s4, dy_s4;
	logic signed [BW-1:0]   wl_s4, wh_s4, sl_s4, sh_s4;
	logic                   w_vert_s4, s_horiz_s4;

	// Classification
	logic                   det_zero, det_neg, num_zero, on_w, on_s;
	logic signed [NW-1:0]   wnum, snum;
	logic signed [CMPW-1:0] wn_e, sn_e, wl_e, wh_e, sl_e, sh_e;

	assign en          = !full;
	assign in_ch.ready = en;
	assign push        = v_s4 && en;

	// Pick the span to test: wall x unless vertical, shot y unless horizontal
	always_comb begin
		w_vert  = (in_ch.wall_bx == in_ch.wall_ax);
		s_horiz = (in_ch.shot_by == in_ch.shot_ay);
		w_p     = w_vert ? in_ch.wall_ay : in_ch.wall_ax;
		w_r     = w_vert ? in_ch.wall_by : in_ch.wall_bx;
		s_p     = s_horiz ? in_ch.shot_ax : in_ch.shot_ay;
		s_r     = s_horiz ? in_ch.shot_bx : in_ch.shot_by;
		wlo     = (w_p < w_r) ? w_p : w_r;
		whi     = (w_p < w_r) ? w_r : w_p;
		slo     = (s_p < s_r) ? s_p : s_r;
		shi     = (s_p < s_r) ? s_r : s_p;
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance the arithmetic pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1      <= DW'(in_ch.wall_by) - DW'(in_ch.wall_ay);
			b1_s1      <= DW'(in_ch.wall_ax) - DW'(in_ch.wall_bx);
			a2_s1      <= DW'(in_ch.shot_by) - DW'(in_ch.shot_ay);
			b2_s1      <= DW'(in_ch.shot_ax) - DW'(in_ch.shot_bx);
			pw1_s1     <= in_ch.wall_ay * in_ch.wall_bx;
			pw2_s1     <= in_ch.wall_ax * in_ch.wall_by;
			ps1_s1     <= in_ch.shot_ay * in_ch.shot_bx;
			ps2_s1     <= in_ch.shot_ax * in_ch.shot_by;
			w_vert_s1  <= w_vert;
			s_horiz_s1 <= s_horiz;
			wlo_s1     <= wlo;
			whi_s1     <= whi;
			slo_s1     <= slo;
			shi_s1     <= shi;

			a1_s2      <= a1_s1;
			b1_s2      <= b1_s1;
			a2_s2      <= a2_s1;
			b2_s2      <= b2_s1;
			c1_s2      <= CPW'(pw1_s1) - CPW'(pw2_s1);
			c2_s2      <= CPW'(ps1_s1) - CPW'(ps2_s1);
			m1_s2      <= a1_s1 * b2_s1;
			m2_s2      <= a2_s1 * b1_s1;
			w_vert_s2  <= w_vert_s1;
			s_horiz_s2 <= s_horiz_s1;
			wlo_s2     <= wlo_s1;
			whi_s2     <= whi_s1;
			slo_s2     <= slo_s1;
			shi_s2     <= shi_s1;

			det_s3     <= DETW'(m1_s2) - DETW'(m2_s2);
			pxa_s3     <= c2_s2 * b1_s2;
			pxb_s3     <= c1_s2 * b2_s2;
			pya_s3     <= a2_s2 * c1_s2;
			pyb_s3     <= a1_s2 * c2_s2;
			w_vert_s3  <= w_vert_s2;
			s_horiz_s3 <= s_horiz_s2;
			wlo_s3     <= wlo_s2;
			whi_s3     <= whi_s2;
			slo_s3     <= slo_s2;
			shi_s3     <= shi_s2;

			det_s4     <= det_s3;
			dx_s4      <= NW'(pxa_s3) - NW'(pxb_s3);
			dy_s4      <= NW'(pya_s3) - NW'(pyb_s3);
			wl_s4      <= wlo_s3 * det_s3;
			wh_s4      <= whi_s3 * det_s3;
			sl_s4      <= slo_s3 * det_s3;
			sh_s4      <= shi_s3 * det_s3;
			w_vert_s4  <= w_vert_s3;
			s_horiz_s4 <= s_horiz_s3;
		end
	end

	// Classify: coincident, parallel, or betweenness on both spans
	always_comb begin
		det_zero = (det_s4 == '0);
		det_neg  = det_s4[DETW-1];
		num_zero = (dx_s4 == '0) && (dy_s4 == '0);
		wnum     = w_vert_s4 ? dy_s4 : dx_s4;
		snum     = s_horiz_s4 ? dx_s4 : dy_s4;
		wn_e     = CMPW'(wnum);
		sn_e     = CMPW'(snum);
		wl_e     = CMPW'(wl_s4);
		wh_e     = CMPW'(wh_s4);
		sl_e     = CMPW'(sl_s4);
		sh_e     = CMPW'(sh_s4);
		// a negative determinant flips both bounds of the span test
		on_w     = det_neg ? (wl_e >= wn_e && wn_e >= wh_e) : (wl_e <= wn_e && wn_e <= wh_e);
		on_s     = det_neg ? (sl_e >= sn_e && sn_e >= sh_e) : (sl_e <= sn_e && sn_e <= sh_e);

		job.coin   = det_zero && num_zero;
		job.proper = !det_zero && on_w && on_s;
		job.hit    = job.coin || job.proper;
		job.neg_x  = dx_s4[NW-1] ^ det_neg;
		job.neg_y  = dy_s4[NW-1] ^ det_neg;
		job.mag_x  = dx_s4[NW-1] ? NW'(-dx_s4) : NW'(dx_s4);
		job.mag_y  = dy_s4[NW-1] ? NW'(-dy_s4) : NW'(dy_s4);
		job.den    = det_neg ? DETW'(-det_s4) : DETW'(det_s4);
	end

endmodule

`default_nettype wire

>>> design/sit_fifo.sv
// Short queue of classified words between the front end and the divider.
`timescale 1ns / 1ps
`default_nettype none

module sit_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sit_pkg::sit_job_t push_job,
	output logic              full,
	input  logic              pop,
	output sit_pkg::sit_job_t pop_job,
	output logic              not_empty
);

	localparam int DEPTH = sit_pkg::FIFO_DEPTH;
	localparam int PW    = sit_pkg::FIFO_PTR_W;
	localparam int CNW   = sit_pkg::FIFO_CNT_W;

	sit_pkg::sit_job_t mem_q [DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CNW-1:0]    cnt_q;

	assign full      = (cnt_q == CNW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_job   = mem_q[rd_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/sit_back.sv
// Back end: pipelined two-lane restoring divider, rounding, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none

module sit_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sit_pkg::sit_job_t job,
	input  logic              job_valid,
	output logic              pop,
	sit_out_if.source         out_ch
);

	localparam int DETW = sit_pkg::DET_W;
	localparam int MAGW = sit_pkg::MAG_W;
	localparam int QW   = sit_pkg::QUO_W;
	localparam int SW   = sit_pkg::SAT_W;
	localparam int PT   = sit_pkg::PT_BITS;
	localparam int FB   = sit_pkg::FRAC_BITS;

	logic               en;
	logic [QW-1:0]      v_s;
	sit_pkg::sit_div_t  dv_s [QW];
	sit_pkg::sit_div_t  last;
	logic               v_o_q;
	sit_pkg::sit_res_t  res_q;

	// Split the scaled magnitudes into starting remainder and digits to bring down
	function automatic sit_pkg::sit_div_t div_init(sit_pkg::sit_job_t j);
		sit_pkg::sit_div_t d;
		logic [MAGW-1:0]   sx, sy;
		sx       = MAGW'(j.mag_x) << FB;
		sy       = MAGW'(j.mag_y) << FB;
		d.hit    = j.hit;
		d.coin   = j.coin;
		d.proper = j.proper;
		d.neg_x  = j.neg_x;
		d.neg_y  = j.neg_y;
		d.den    = j.den;
		d.rem_x  = sx[MAGW-1:QW];
		d.rem_y  = sy[MAGW-1:QW];
		d.low_x  = sx[QW-1:0];
		d.low_y  = sy[QW-1:0];
		d.q_x    = '0;
		d.q_y    = '0;
		return d;
	endfunction

	// One quotient digit for each lane
	function automatic sit_pkg::sit_div_t div_step(sit_pkg::sit_div_t d);
		sit_pkg::sit_div_t r;
		logic [DETW:0]     tx, ty, dn;
		logic              gx, gy;
		r       = d;
		dn      = {1'b0, d.den};
		tx      = {d.rem_x, d.low_x[QW-1]};
		ty      = {d.rem_y, d.low_y[QW-1]};
		gx      = (tx >= dn);
		gy      = (ty >= dn);
		r.rem_x = gx ? DETW'(tx - dn) : tx[DETW-1:0];
		r.rem_y = gy ? DETW'(ty - dn) : ty[DETW-1:0];
		r.low_x = d.low_x << 1;
		r.low_y = d.low_y << 1;
		r.q_x   = {d.q_x[QW-2:0], gx};
		r.q_y   = {d.q_y[QW-2:0], gy};
		return r;
	endfunction

	// Round to nearest with ties away from zero, clamp, and apply the sign
	function automatic logic [PT-1:0] fin(logic [QW-1:0] q, logic [DETW-1:0] rem,
			logic [DETW-1:0] den, logic neg);
		logic          up;
		logic [SW-1:0] qr, lim, v;
		up  = (({1'b0, rem} << 1) >= {1'b0, den});
		qr  = SW'(q) + SW'(up);
		lim = neg ? (SW'(1) << (PT - 1)) : ((SW'(1) << (PT - 1)) - SW'(1));
		v   = (qr > lim) ? lim : qr;
		return neg ? PT'(-v) : PT'(v);
	endfunction

	assign en   = !v_o_q || out_ch.ready;
	assign pop  = en && job_valid;
	assign last = dv_s[QW-1];

	assign out_ch.valid      = v_o_q;
	assign out_ch.hit        = res_q.hit;
	assign out_ch.coincident = res_q.coin;
	assign out_ch.point_x    = res_q.px;
	assign out_ch.point_y    = res_q.py;

	// Advance stage valids and the output flag together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s   <= '0;
			v_o_q <= 1'b0;
		end else if (en) begin
			v_s   <= {v_s[QW-2:0], job_valid};
			v_o_q <= v_s[QW-1];
		end
	end

	// Advance the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= div_step(div_init(job));
			for (int k = 1; k < QW; k++) begin
				dv_s[k] <= div_step(dv_s[k-1]);
			end
		end
	end

	// Hold the finished word until taken; point is zero unless a proper hit
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.hit  <= last.hit;
			res_q.coin <= last.coin;
			res_q.px   <= last.proper ? fin(last.q_x, last.rem_x, last.den, last.neg_x) : '0;
			res_q.py   <= last.proper ? fin(last.q_y, last.rem_y, last.den, last.neg_y) : '0;
		end
	end

endmodule

`default_nettype wire

>>> design/segment_intersection_test.sv
// Top level of the wall/shot segment intersection test.
//
// in_ch carries one word per segment pair: wall and shot endpoints as signed
// integers. out_ch returns one word per input word, in order: hit, coincident
// and the intersection point in Q.8 fixed point (zero unless a proper hit).
// Both channels use valid/ready; a word moves on a clock edge with both high.
//
// Throughput: one word per cycle while out_ch.ready stays high.
// Path: four front stages of multipliers (the first loaded at the input edge),
// one queue slot, then one divider stage per quotient digit (24 digits) and the
// output register.
//
// The front end stalls only when the four-entry queue is full; the divider
// and output register stall together while an output word waits for ready,
// and the queue absorbs the words still in flight in the front end.
// Reset (arst_n low) empties the pipelines, the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_test (
	input  logic      clk,
	input  logic      arst_n,
	sit_in_if.sink    in_ch,
	sit_out_if.source out_ch
);

	sit_pkg::sit_job_t push_job, pop_job;
	logic              push, full, pop, not_empty;

	// Classify segment pairs
	sit_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.full     (full),
		.push     (push),
		.job      (push_job)
	);

	// Decouple front and divider
	sit_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (not_empty)
	);

	// Divide, round and deliver
	sit_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.job_valid (not_empty),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

>>> design/sit_checker.sv
// Port-level checks of the segment intersection test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sit_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              hit,
	input logic                              coincident,
	input logic signed [sit_pkg::PT_BITS-1:0] point_x,
	input logic signed [sit_pkg::PT_BITS-1:0] point_y
);

	// Hold a stalled output word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(coincident)
			&& $stable(point_x) && $stable(point_y))
		else $error("output word changed while stalled");

	// Coincident lines always count as a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coincident |-> hit)
		else $error("coincident without hit");

	// Drop the point unless the hit is proper
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(hit && !coincident) |-> point_x == '0 && point_y == '0)
		else $error("nonzero point without a proper hit");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.hit        (out_ch.hit),
	.coincident (out_ch.coincident),
	.point_x    (out_ch.point_x),
	.point_y    (out_ch.point_y)
);

`default_nettype wire
